/* rtl/core/decimal_gamma_encoder_unit_macros.svh */
// ----------------------------------------------------------------------------
// Decimal gamma encoder assertion macros
// Shared property templates for the encoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_GAMMA_ENCODER_UNIT_MACROS_SVH
`define DECIMAL_GAMMA_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DGE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("decimal gamma encoder: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DGE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("decimal gamma encoder: next-cycle check failed");

`endif

/* rtl/core/dge_pkg.sv */
// ----------------------------------------------------------------------------
// Decimal gamma encoder package
// Widths, constants and request/result types shared by the encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dge_pkg;

	// Width of the saturating exponent offset field.
	localparam int EXP_WIDTH = 16;

	localparam int ABS_EXP_W = 16;
	localparam int DIGIT_W   = 4;
	localparam int CODE_W    = 37;
	localparam int LEN_W     = 6;
	localparam int DECLET_W  = 10;

	// The offset sum needs one bit more than the exponent field.
	localparam int SUM_W  = (EXP_WIDTH > ABS_EXP_W + 1) ? EXP_WIDTH : ABS_EXP_W + 1;
	// Bit length of the offset, 0 .. EXP_WIDTH.
	localparam int BLEN_W = $clog2(EXP_WIDTH + 1);
	// Full header length is 2*EXP_WIDTH + 5 at most.
	localparam int FULL_W = 2 * EXP_WIDTH + 5;
	localparam int WORD_W = (FULL_W > CODE_W) ? FULL_W : CODE_W;
	localparam int SHAMT_W = BLEN_W + 2;

	localparam logic [EXP_WIDTH-1:0] MAX_OFFSET = '1;

	localparam logic OP_HEADER = 1'b0;
	localparam logic OP_GROUP  = 1'b1;

	localparam logic [1:0] SIGN_POSITIVE = 2'b10;
	localparam logic [1:0] SIGN_NEGATIVE = 2'b00;
	localparam logic [SUM_W-1:0] OFFSET_BIAS = SUM_W'(2);
	localparam logic [DIGIT_W-1:0] DIGIT_BASE = DIGIT_W'(10);
	localparam logic [DECLET_W-1:0] DECLET_BASE      = DECLET_W'(999);
	localparam logic [DECLET_W-1:0] DECLET_LAST_BASE = DECLET_W'(1000);
	localparam logic [LEN_W-1:0] ZERO_LENGTH   = LEN_W'(2);
	localparam logic [LEN_W-1:0] DECLET_LENGTH = LEN_W'(DECLET_W);

	typedef struct packed {
		logic                 opcode;
		logic                 negative;
		logic                 is_zero;
		logic                 exponent_negative;
		logic [ABS_EXP_W-1:0] abs_exponent;
		logic [DIGIT_W-1:0]   lead_digit;
		logic [DIGIT_W-1:0]   digit_hi;
		logic [DIGIT_W-1:0]   digit_mid;
		logic [DIGIT_W-1:0]   digit_lo;
		logic                 last_group;
	} in_item_t;

	typedef struct packed {
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_length;
		logic              number_done;
	} out_item_t;

endpackage

`default_nettype wire

/* rtl/core/decimal_gamma_encoder_unit.sv */
// ----------------------------------------------------------------------------
// Decimal gamma encoder unit
// Streams normalized decimal numbers into an order-preserving bit code.
// ----------------------------------------------------------------------------
// A number is sent as one header request followed by its three-digit group
// requests, and every request yields exactly one code chunk: right-aligned
// bits, a bit count and a flag that marks the chunk ending the number. The
// unit takes one request per clock while its input does not stall: a request
// is captured in the input register, encoded in one pass of short logic, and
// held in the result register until the consumer takes it. The input stalls
// only when both registers are full and the output is stalled, so throughput
// is set by the consumer alone. The sign of the current number is kept
// between a header and its groups; it is cleared by reset and by a zero
// header, which produces only the two sign bits and ends the number.
// ----------------------------------------------------------------------------
`default_nettype none

`include "decimal_gamma_encoder_unit_macros.svh"

module decimal_gamma_encoder_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  dge_pkg::in_item_t  item,
	output logic               code_valid,
	input  logic               code_stall,
	output dge_pkg::out_item_t code
);
	import dge_pkg::*;

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t code_s2;
	logic      valid_s2;
	logic      sign_q;

	out_item_t hdr_code;
	out_item_t grp_code;
	out_item_t enc_code;
	logic      hdr_sign;
	logic      advance;
	logic      take;

	// The first stage moves on whenever the result register is free or drained.
	assign advance    = valid_s1 && (!valid_s2 || !code_stall);
	assign item_stall = valid_s1 && !advance;
	assign take       = item_valid && !item_stall;

	dge_header_enc u_header (
		.item      (item_s1),
		.code      (hdr_code),
		.sign_next (hdr_sign)
	);

	dge_group_enc u_group (
		.item          (item_s1),
		.sign_negative (sign_q),
		.code          (grp_code)
	);

	assign enc_code = (item_s1.opcode == OP_HEADER) ? hdr_code : grp_code;

	// Input register: payload loads only on an accepted request.
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Result register: holds its chunk for as long as the consumer stalls.
	always_ff @(posedge clk) begin
		if (advance) begin
			code_s2 <= enc_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!code_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// The number's sign changes only when a header leaves the first stage, so
	// a group right behind its header already sees the new sign.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sign_q <= 1'b0;
		end else if (advance && (item_s1.opcode == OP_HEADER)) begin
			sign_q <= hdr_sign;
		end
	end

	assign code_valid = valid_s2;
	assign code       = code_s2;

	// A stall toward the producer only happens with a request held in stage one.
	`DGE_ASSERT_SAME(a_stall_needs_item, clk, arst_n, item_stall, valid_s1)

	// A request that moves on is offered to the consumer in the next cycle.
	`DGE_ASSERT_NEXT(a_advance_gives_code, clk, arst_n, advance, code_valid)

	// Chunks are a zero header, a declet, or a header of odd length.
	`DGE_ASSERT_SAME(a_code_length_shape, clk, arst_n, code_valid, (code.code_length == ZERO_LENGTH) || (code.code_length == DECLET_LENGTH) || code.code_length[0])

	// A zero header leaves the stored sign positive.
	`DGE_ASSERT_NEXT(a_zero_clears_sign, clk, arst_n, advance && (item_s1.opcode == OP_HEADER) && item_s1.is_zero, !sign_q)

endmodule

`default_nettype wire

/* rtl/core/dge_header_enc.sv */
// ----------------------------------------------------------------------------
// Decimal gamma header encoder
// Builds the sign bits, gamma exponent and first digit of one header.
// ----------------------------------------------------------------------------
`default_nettype none

module dge_header_enc (
	input  dge_pkg::in_item_t  item,
	output dge_pkg::out_item_t code,
	output logic               sign_next
);
	import dge_pkg::*;

	logic [SUM_W-1:0]     offset_sum;
	logic [EXP_WIDTH-1:0] offset;
	logic [BLEN_W-1:0]    blen;
	logic [BLEN_W-1:0]    blen_m1;
	logic [SHAMT_W-1:0]   sign_shift;
	logic [WORD_W-1:0]    len_mask;
	logic [WORD_W-1:0]    rest_mask;
	logic [WORD_W-1:0]    field;
	logic [WORD_W-1:0]    field_mask;
	logic [WORD_W-1:0]    word;
	logic [DIGIT_W-1:0]   first;
	logic [1:0]           sign_code;

	// Offset is the exponent plus two, saturated to the field width.
	assign offset_sum = SUM_W'(item.abs_exponent) + OFFSET_BIAS;
	assign offset = (offset_sum > SUM_W'(MAX_OFFSET)) ? MAX_OFFSET
		: offset_sum[EXP_WIDTH-1:0];

	// Bit length of the offset: position of the highest set bit plus one.
	always_comb begin
		blen = '0;
		for (int i = 0; i < EXP_WIDTH; i++) begin
			if (offset[i]) begin
				blen = BLEN_W'(i + 1);
			end
		end
	end

	assign blen_m1    = blen - BLEN_W'(1);
	assign len_mask   = (WORD_W'(1) << blen) - WORD_W'(1);
	assign rest_mask  = len_mask >> 1;
	assign field_mask = (len_mask << blen_m1) | rest_mask;
	assign sign_shift = SHAMT_W'(blen) + SHAMT_W'(blen_m1) + SHAMT_W'(DIGIT_W);

	// Unary prefix of ones closed by a zero, then the offset below its top bit.
	always_comb begin
		field = ((len_mask - WORD_W'(1)) << blen_m1) | (WORD_W'(offset) & rest_mask);
		if (item.negative != item.exponent_negative) begin
			field = field ^ field_mask;
		end
	end

	assign first     = item.negative ? (DIGIT_BASE - item.lead_digit) : item.lead_digit;
	assign sign_code = item.negative ? SIGN_NEGATIVE : SIGN_POSITIVE;
	assign word      = (WORD_W'(sign_code) << sign_shift) | (field << DIGIT_W)
		| WORD_W'(first);

	always_comb begin
		if (item.is_zero) begin
			code.code_bits   = CODE_W'(SIGN_POSITIVE);
			code.code_length = ZERO_LENGTH;
			code.number_done = 1'b1;
			sign_next        = 1'b0;
		end else begin
			code.code_bits   = word[CODE_W-1:0];
			code.code_length = LEN_W'({blen, 1'b1}) + LEN_W'(DIGIT_W);
			code.number_done = 1'b0;
			sign_next        = item.negative;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/dge_group_enc.sv */
// ----------------------------------------------------------------------------
// Decimal gamma group encoder
// Packs three decimal digits into one 10-bit declet, complemented if negative.
// ----------------------------------------------------------------------------
`default_nettype none

module dge_group_enc (
	input  dge_pkg::in_item_t  item,
	input  logic               sign_negative,
	output dge_pkg::out_item_t code
);
	import dge_pkg::*;

	logic [DECLET_W-1:0] value;
	logic [DECLET_W-1:0] declet;

	// All arithmetic wraps at ten bits.
	assign value = DECLET_W'(item.digit_hi) * DECLET_W'(100)
		+ DECLET_W'(item.digit_mid) * DECLET_W'(10)
		+ DECLET_W'(item.digit_lo);

	always_comb begin
		if (sign_negative) begin
			declet = (item.last_group ? DECLET_LAST_BASE : DECLET_BASE) - value;
		end else begin
			declet = value;
		end
	end

	assign code.code_bits   = CODE_W'(declet);
	assign code.code_length = DECLET_LENGTH;
	assign code.number_done = item.last_group;

endmodule

`default_nettype wire

/* tb/sv/decimal_gamma_chunk_checker.sv */
// ----------------------------------------------------------------------------
// Decimal gamma chunk checker
// Watches both channels of the encoder and predicts every code chunk from
// the accepted requests. It compares each chunk field by field, in order,
// and reports the mismatch count and the number of chunks still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module decimal_gamma_chunk_checker
	import dge_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  logic      item_stall,
	input  in_item_t  item,
	input  logic      code_valid,
	input  logic      code_stall,
	input  out_item_t code,
	output int        fail_count,
	output int        pending_count
);

	localparam logic [63:0] OFFSET_LIMIT = (64'd1 << EXP_WIDTH) - 64'd1;

	out_item_t expected_chunks[$];
	logic      number_negative = 1'b0;
	int        mismatch_total  = 0;

	assign fail_count = mismatch_total;

	// Encodes one request, given the sign stored by the latest header.
	function automatic out_item_t encode_chunk(input in_item_t req, input logic sign_neg);
		out_item_t   chunk;
		logic [63:0] offset;
		logic [63:0] pmask;
		logic [63:0] rmask;
		logic [63:0] prefix;
		logic [63:0] rest;
		logic [63:0] word;
		logic [3:0]  first;
		logic [9:0]  declet;
		int          blen;
		int          value;
		chunk = '0;
		if (req.opcode == OP_HEADER) begin
			if (req.is_zero) begin
				chunk.code_bits   = CODE_W'(SIGN_POSITIVE);
				chunk.code_length = LEN_W'(2);
				chunk.number_done = 1'b1;
			end else begin
				offset = 64'(req.abs_exponent) + 64'd2;
				if (offset > OFFSET_LIMIT) begin
					offset = OFFSET_LIMIT;
				end
				blen = 0;
				for (int b = 0; b < 64; b++) begin
					if (offset[b]) begin
						blen = b + 1;
					end
				end
				pmask  = (64'd1 << blen) - 64'd1;
				rmask  = (64'd1 << (blen - 1)) - 64'd1;
				prefix = pmask - 64'd1;
				rest   = offset & rmask;
				if (req.negative != req.exponent_negative) begin
					prefix = prefix ^ pmask;
					rest   = rest ^ rmask;
				end
				first = req.negative ? 4'd10 - req.lead_digit : req.lead_digit;
				word  = req.negative ? 64'(SIGN_NEGATIVE) : 64'(SIGN_POSITIVE);
				word  = (word << blen) | prefix;
				word  = (word << (blen - 1)) | rest;
				word  = (word << 4) | 64'(first);
				chunk.code_bits   = word[CODE_W-1:0];
				chunk.code_length = LEN_W'(2 * blen + 5);
				chunk.number_done = 1'b0;
			end
		end else begin
			value = 100 * int'(req.digit_hi) + 10 * int'(req.digit_mid) + int'(req.digit_lo);
			if (sign_neg) begin
				value = (req.last_group ? 1000 : 999) - value;
			end
			declet = 10'(value);
			chunk.code_bits   = CODE_W'(declet);
			chunk.code_length = LEN_W'(10);
			chunk.number_done = req.last_group;
		end
		return chunk;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			expected_chunks.delete();
			number_negative = 1'b0;
			pending_count <= 0;
		end else begin
			// Results leave first: a request accepted now cannot be answered on this edge.
			if (code_valid && !code_stall) begin
				if (expected_chunks.size() == 0) begin
					$display("%0t: chunk with nothing expected, actual bits %h length %0d done %b",
						$time, code.code_bits, code.code_length, code.number_done);
					mismatch_total++;
				end else begin
					want = expected_chunks.pop_front();
					if (code.code_bits !== want.code_bits) begin
						$display("%0t: code_bits mismatch, expected %h, actual %h",
							$time, want.code_bits, code.code_bits);
						mismatch_total++;
					end
					if (code.code_length !== want.code_length) begin
						$display("%0t: code_length mismatch, expected %0d, actual %0d",
							$time, want.code_length, code.code_length);
						mismatch_total++;
					end
					if (code.number_done !== want.number_done) begin
						$display("%0t: number_done mismatch, expected %b, actual %b",
							$time, want.number_done, code.number_done);
						mismatch_total++;
					end
				end
			end
			if (item_valid && !item_stall) begin
				expected_chunks.push_back(encode_chunk(item, number_negative));
				if (item.opcode == OP_HEADER) begin
					number_negative = item.negative && !item.is_zero;
				end
			end
			pending_count <= expected_chunks.size();
		end
	end

endmodule

/* tb/sv/tb_decimal_gamma_encoder_unit.sv */
// ----------------------------------------------------------------------------
// Decimal gamma encoder unit testbench
// Drives headers and digit groups into the encoder through a short directed
// sequence and then random numbers under several idle and stall patterns.
// A checker beside the unit predicts and compares every chunk; this module
// makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_decimal_gamma_encoder_unit;
	import dge_pkg::*;

	// Generous bound on the whole run, in clock cycles.
	localparam int CYCLE_LIMIT = 400000;
	// Random requests per idle and stall phase.
	localparam int PHASE_REQUESTS = 170;

	logic      clk        = 1'b0;
	logic      arst_n     = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_stall;
	in_item_t  item       = '0;
	logic      code_valid;
	logic      code_stall = 1'b0;
	out_item_t code;

	int fail_count;
	int pending_count;
	int cycle_count        = 0;
	int requests_sent      = 0;
	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int sender_calm        = 0;
	int receiver_calm      = 0;

	// Idle and stall chances, in percent, for each phase of the random part.
	int idle_plan[4]  = '{0, 63, 0, 14};
	int stall_plan[4] = '{0, 0, 63, 14};

	decimal_gamma_encoder_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code       (code)
	);

	decimal_gamma_chunk_checker chunk_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.item          (item),
		.code_valid    (code_valid),
		.code_stall    (code_stall),
		.code          (code),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// The watchdog ends a run that hangs, for instance when a chunk never comes out.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// The consumer stalls at the phase's rate, broken now and then by a stretch
	// in which it takes every chunk, so that stalls land on every stage of the pipe.
	always @(posedge clk) begin
		if (receiver_calm > 0) begin
			receiver_calm <= receiver_calm - 1;
			code_stall    <= 1'b0;
		end else if ($urandom_range(199) == 0) begin
			receiver_calm <= $urandom_range(60, 20);
			code_stall    <= 1'b0;
		end else begin
			code_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	// Every bit of the request drawn at random; the fields a request does not
	// use carry this noise too, since the unit must ignore them.
	function automatic in_item_t noise_item();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		return raw[$bits(in_item_t)-1:0];
	endfunction

	function automatic in_item_t header_item(input logic neg, input logic zero,
		input logic eneg, input logic [15:0] aexp, input logic [3:0] lead);
		in_item_t req;
		req = noise_item();
		req.opcode            = OP_HEADER;
		req.negative          = neg;
		req.is_zero           = zero;
		req.exponent_negative = eneg;
		req.abs_exponent      = aexp;
		req.lead_digit        = lead;
		return req;
	endfunction

	function automatic in_item_t group_item(input logic [3:0] hi, input logic [3:0] mid,
		input logic [3:0] lo, input logic last);
		in_item_t req;
		req = noise_item();
		req.opcode     = OP_GROUP;
		req.digit_hi   = hi;
		req.digit_mid  = mid;
		req.digit_lo   = lo;
		req.last_group = last;
		return req;
	endfunction

	// A decimal digit, or any 4-bit value when a malformed digit is wanted.
	function automatic logic [3:0] pick_digit(input logic wild);
		return wild ? 4'($urandom_range(15)) : 4'($urandom_range(9));
	endfunction

	// Offers one request and returns at the edge that accepts it. The stall
	// is looked at on the falling edge, where it has settled for the next
	// rising edge, so acceptance never hinges on event order at the edge.
	task automatic send_request(input in_item_t req);
		if (sender_calm > 0) begin
			sender_calm--;
		end else begin
			if ($urandom_range(39) == 0) begin
				sender_calm = $urandom_range(40, 15);
			end
			while ($urandom_range(99) < sender_idle_pct) begin
				item_valid <= 1'b0;
				item       <= noise_item();
				@(posedge clk);
			end
		end
		item_valid <= 1'b1;
		item       <= req;
		@(negedge clk);
		while (item_stall) begin
			@(negedge clk);
		end
		@(posedge clk);
		requests_sent++;
	endtask

	initial begin
		logic       neg;
		logic       zero;
		logic       wild;
		logic [15:0] aexp;
		int         groups;
		int         target;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A group straight after reset uses the cleared sign.
		send_request(group_item(4'd9, 4'd9, 4'd9, 1'b0));
		// Zero headers, the second one with the negative flag that zero overrides,
		// and a group after a zero header, which keeps the positive sign.
		send_request(header_item(1'b0, 1'b1, 1'b0, 16'd0, 4'd0));
		send_request(header_item(1'b1, 1'b1, 1'b1, 16'hffff, 4'd15));
		send_request(group_item(4'd1, 4'd2, 4'd3, 1'b1));
		// Smallest offset, with the smallest and largest declets.
		send_request(header_item(1'b0, 1'b0, 1'b0, 16'd0, 4'd1));
		send_request(group_item(4'd0, 4'd0, 4'd0, 1'b0));
		send_request(group_item(4'd9, 4'd9, 4'd9, 1'b1));
		// Negative number with a negative exponent: signs agree, nothing inverted.
		// Its declets go through both complements, including 1000 minus zero.
		send_request(header_item(1'b1, 1'b0, 1'b1, 16'd0, 4'd9));
		send_request(group_item(4'd0, 4'd0, 4'd0, 1'b0));
		send_request(group_item(4'd0, 4'd0, 4'd0, 1'b1));
		send_request(group_item(4'd9, 4'd9, 4'd9, 1'b1));
		// A group after the last group still sees the stored negative sign.
		send_request(group_item(4'd5, 4'd5, 4'd5, 1'b0));
		// Largest legal exponent on a negative number with a zero lead digit,
		// then out-of-range digits whose declet wraps.
		send_request(header_item(1'b1, 1'b0, 1'b0, 16'd65533, 4'd0));
		send_request(group_item(4'd15, 4'd15, 4'd15, 1'b1));
		// Exponents past the legal range saturate the offset.
		send_request(header_item(1'b0, 1'b0, 1'b1, 16'hffff, 4'd15));
		send_request(group_item(4'd15, 4'd15, 4'd15, 1'b1));
		send_request(header_item(1'b0, 1'b0, 1'b0, 16'd65534, 4'd9));
		send_request(group_item(4'd0, 4'd0, 4'd1, 1'b1));
		// Ten minus a lead digit above ten wraps in four bits.
		send_request(header_item(1'b1, 1'b0, 1'b1, 16'hffff, 4'd15));
		send_request(group_item(4'd0, 4'd0, 4'd1, 1'b1));
		send_request(header_item(1'b0, 1'b0, 1'b1, 16'd1, 4'd5));
		send_request(group_item(4'd1, 4'd0, 4'd0, 1'b1));
		send_request(header_item(1'b1, 1'b0, 1'b0, 16'd6, 4'd3));
		send_request(group_item(4'd0, 4'd0, 4'd0, 1'b1));

		// Random part. Most traffic is whole numbers: a header followed by its
		// groups with the last one flagged. About one case in ten is broken:
		// a header left without groups, a stray group, a number whose last
		// flag never comes, or a request of pure noise.
		for (int phase = 0; phase < 4; phase++) begin
			sender_idle_pct    = idle_plan[phase];
			receiver_stall_pct <= stall_plan[phase];
			target = requests_sent + PHASE_REQUESTS;
			while (requests_sent < target) begin
				neg  = 1'($urandom_range(1));
				zero = ($urandom_range(11) == 0);
				wild = ($urandom_range(19) == 0);
				case ($urandom_range(9))
					0, 1, 2, 3, 4, 5: aexp = 16'($urandom_range(30));
					6, 7:             aexp = 16'($urandom_range(1000));
					8:                aexp = 16'($urandom_range(65535));
					default:          aexp = 16'($urandom_range(65535, 65528));
				endcase
				groups = zero ? 0 : $urandom_range(4, 1);
				if ($urandom_range(9) == 0) begin
					case ($urandom_range(3))
						0: send_request(header_item(neg, 1'b0, 1'($urandom_range(1)), aexp,
							pick_digit(1'b1)));
						1: send_request(group_item(pick_digit(1'b1), pick_digit(1'b1),
							pick_digit(1'b1), 1'($urandom_range(1))));
						2: begin
							send_request(header_item(neg, 1'b0, 1'($urandom_range(1)), aexp,
								pick_digit(wild)));
							repeat (groups) begin
								send_request(group_item(pick_digit(wild), pick_digit(wild),
									pick_digit(wild), 1'b0));
							end
						end
						default: send_request(noise_item());
					endcase
				end else begin
					send_request(header_item(neg, zero, 1'($urandom_range(1)), aexp,
						wild ? pick_digit(1'b1) : 4'($urandom_range(9, 1))));
					for (int g = 0; g < groups; g++) begin
						send_request(group_item(pick_digit(wild), pick_digit(wild),
							pick_digit(wild), g == groups - 1));
					end
				end
			end
		end
		item_valid <= 1'b0;

		// Drain: the count seen on this edge already includes the final request.
		@(posedge clk);
		while (pending_count != 0) begin
			@(posedge clk);
		end
		// Keep the clock running after the drain to catch stray chunks.
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
